>>> rtl/core/etmr_pkg.sv
// Shared types and codes for the event timer table.
`timescale 1ns / 1ps
`default_nettype none

package etmr_pkg;

    // Request opcodes
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_ADD  = 1'b1;

    // Result kinds
    localparam logic [1:0] KIND_ADDED    = 2'd0;
    localparam logic [1:0] KIND_REJECTED = 2'd1;
    localparam logic [1:0] KIND_UPDATE   = 2'd2;
    localparam logic [1:0] KIND_EXPIRY   = 2'd3;

    // Most results one tick may report; later ones are dropped
    localparam int MAX_RESULTS = 32;

    typedef struct packed {
        logic        opcode;
        logic [31:0] delta_time;
        logic [31:0] duration;
        logic        repeat_req;
        logic [7:0]  event_tag;
        logic        notify_update;
        logic        notify_end;
    } t_request;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  reported_tag;
        logic [31:0] elapsed;
        logic        last;
    } t_result;

    // Fixed-width part of one stored entry
    typedef struct packed {
        logic [7:0] label;
        logic       repeats;
        logic       wants_update;
        logic       wants_end;
    } t_entry_attr;

    // Per-cell load/shift selects
    typedef struct packed {
        logic load;
        logic take_right;
        logic take_head;
    } t_cell_ctrl;

endpackage

`default_nettype wire

>>> rtl/core/etmr_cell.sv
// One timer entry cell of the rotating chain.
`timescale 1ns / 1ps
`default_nettype none

module etmr_cell
    import etmr_pkg::*;
#(
    parameter int TIME_BITS = 32
) (
    input  wire logic                 i_clk,
    input  wire t_cell_ctrl           i_ctrl,
    input  wire t_entry_attr          i_load_attr,
    input  wire logic [TIME_BITS-1:0] i_load_limit,
    input  wire t_entry_attr          i_right_attr,
    input  wire logic [TIME_BITS-1:0] i_right_limit,
    input  wire logic [TIME_BITS-1:0] i_right_time,
    input  wire t_entry_attr          i_head_attr,
    input  wire logic [TIME_BITS-1:0] i_head_limit,
    input  wire logic [TIME_BITS-1:0] i_head_time,
    output t_entry_attr               o_attr,
    output logic [TIME_BITS-1:0]      o_limit,
    output logic [TIME_BITS-1:0]      o_time
);

    t_entry_attr          r_attr,  n_attr;
    logic [TIME_BITS-1:0] r_limit, n_limit;
    logic [TIME_BITS-1:0] r_time,  n_time;

    // new entry, neighbor shift, or processed head re-entering at the tail
    always_comb begin
        n_attr  = r_attr;
        n_limit = r_limit;
        n_time  = r_time;
        if (i_ctrl.load) begin
            n_attr  = i_load_attr;
            n_limit = i_load_limit;
            n_time  = '0;
        end else if (i_ctrl.take_right) begin
            n_attr  = i_right_attr;
            n_limit = i_right_limit;
            n_time  = i_right_time;
        end else if (i_ctrl.take_head) begin
            n_attr  = i_head_attr;
            n_limit = i_head_limit;
            n_time  = i_head_time;
        end
    end

    always_ff @(posedge i_clk) begin
        r_attr  <= n_attr;
        r_limit <= n_limit;
        r_time  <= n_time;
    end

    assign o_attr  = r_attr;
    assign o_limit = r_limit;
    assign o_time  = r_time;

endmodule

`default_nettype wire

>>> rtl/core/event_timer_table_unit.sv
// Top level of the event timer table: cell chain, head processing and result output.
//
// Usage: drive i_req and raise i_start; the request is taken at a clock edge with
// i_start high and o_busy low. An add request stores an entry at the tail of the
// chain (or is rejected when all EVENT_SLOTS cells are in use) and reports one
// result, sent out from the flush state. A tick request rotates the chain twice
// through its head: the first pass accumulates delta_time into each entry and
// reports updates, the second pass checks expiry, restarts repeating entries and
// drops expired one-shot entries while the chain closes up. Each stored entry
// visits the head once per pass; o_busy stays high through both passes and the
// flush state, and the final result appears as o_busy falls.
// Results appear for one cycle with o_strobe high; o_result.last marks the final
// result of a request. One result is held back so that last is known when it
// leaves. The receiver cannot stall; results are never held off.
// Reset empties the table and returns the block to idle; entry storage itself
// is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module event_timer_table_unit
    import etmr_pkg::*;
#(
    parameter int EVENT_SLOTS = 16,
    parameter int TIME_BITS   = 32
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_start,
    input  wire t_request i_req,
    output logic          o_busy,
    output logic          o_strobe,
    output t_result       o_result
);

    localparam int CNT_W  = $clog2(EVENT_SLOTS + 1);
    localparam int SUM_W  = ((TIME_BITS > 32) ? TIME_BITS : 32) + 1;
    localparam int NRES_W = $clog2(MAX_RESULTS + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_UPD   = 2'd1;
    localparam logic [1:0] ST_EXP   = 2'd2;
    localparam logic [1:0] ST_FLUSH = 2'd3;

    logic [1:0]        r_state;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_left;
    logic [31:0]       r_delta;
    logic [NRES_W-1:0] r_nres;
    logic              r_pend_vld;
    t_result           r_pend;
    logic              r_strobe;
    t_result           r_out;

    t_entry_attr          w_attr  [EVENT_SLOTS];
    logic [TIME_BITS-1:0] w_limit [EVENT_SLOTS];
    logic [TIME_BITS-1:0] w_time  [EVENT_SLOTS];
    t_entry_attr          w_rattr  [EVENT_SLOTS];
    logic [TIME_BITS-1:0] w_rlimit [EVENT_SLOTS];
    logic [TIME_BITS-1:0] w_rtime  [EVENT_SLOTS];
    t_cell_ctrl           w_ctrl   [EVENT_SLOTS];

    logic                 w_accept;
    logic                 w_full;
    logic                 w_do_load;
    logic                 w_shift;
    logic                 w_drop;
    logic [SUM_W-1:0]     w_dur_ext;
    logic [TIME_BITS-1:0] w_load_limit;
    t_entry_attr          w_load_attr;
    logic [SUM_W-1:0]     w_sum;
    logic [TIME_BITS-1:0] w_acc;
    logic                 w_expired;
    logic [TIME_BITS-1:0] w_head_time;
    logic [TIME_BITS-1:0] w_rep_time;
    logic [SUM_W-1:0]     w_rep_ext;
    logic                 w_new_vld;
    t_result              w_new;

    assign w_accept = i_start && (r_state == ST_IDLE);
    assign w_full   = (r_count == CNT_W'(EVENT_SLOTS));
    assign w_do_load = w_accept && (i_req.opcode == OP_ADD) && !w_full;

    // New entry, duration masked to the stored width
    assign w_dur_ext    = SUM_W'(i_req.duration);
    assign w_load_limit = w_dur_ext[TIME_BITS-1:0];
    assign w_load_attr  = '{label: i_req.event_tag, repeats: i_req.repeat_req,
                            wants_update: i_req.notify_update,
                            wants_end: i_req.notify_end};

    // Head processing: saturating accumulate and expiry check on cell 0
    assign w_sum     = SUM_W'(w_time[0]) + SUM_W'(r_delta);
    assign w_acc     = (|w_sum[SUM_W-1:TIME_BITS]) ? '1 : w_sum[TIME_BITS-1:0];
    assign w_expired = (w_limit[0] < w_time[0]);
    assign w_shift   = (r_state == ST_UPD) || (r_state == ST_EXP);
    assign w_drop    = (r_state == ST_EXP) && w_expired && !w_attr[0].repeats;

    always_comb begin
        if (r_state == ST_UPD) begin
            w_head_time = w_acc;
        end else if (w_expired && w_attr[0].repeats) begin
            w_head_time = '0;
        end else begin
            w_head_time = w_time[0];
        end
    end

    // Reported elapsed value, cut or widened to 32 bits
    assign w_rep_time = (r_state == ST_UPD) ? w_acc : w_time[0];
    assign w_rep_ext  = SUM_W'(w_rep_time);

    always_comb begin
        w_new_vld = 1'b0;
        w_new     = '{kind: KIND_UPDATE, reported_tag: w_attr[0].label,
                      elapsed: w_rep_ext[31:0], last: 1'b0};
        case (r_state)
            ST_UPD: begin
                w_new_vld = w_attr[0].wants_update;
            end
            ST_EXP: begin
                w_new_vld  = w_expired && w_attr[0].wants_end;
                w_new.kind = KIND_EXPIRY;
            end
            default: begin
                w_new_vld = 1'b0;
            end
        endcase
    end

    // Cell chain: entries move toward cell 0, the head re-enters at the tail
    for (genvar i = 0; i < EVENT_SLOTS; i++) begin : g_cell
        if (i == EVENT_SLOTS - 1) begin : g_end
            assign w_rattr[i]  = '0;
            assign w_rlimit[i] = '0;
            assign w_rtime[i]  = '0;
        end else begin : g_mid
            assign w_rattr[i]  = w_attr[i+1];
            assign w_rlimit[i] = w_limit[i+1];
            assign w_rtime[i]  = w_time[i+1];
        end

        assign w_ctrl[i].load       = w_do_load && (CNT_W'(i) == r_count);
        assign w_ctrl[i].take_right = w_shift && (CNT_W'(i + 1) < r_count);
        assign w_ctrl[i].take_head  = w_shift && !w_drop && (CNT_W'(i + 1) == r_count);

        etmr_cell #(
            .TIME_BITS(TIME_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (w_ctrl[i]),
            .i_load_attr  (w_load_attr),
            .i_load_limit (w_load_limit),
            .i_right_attr (w_rattr[i]),
            .i_right_limit(w_rlimit[i]),
            .i_right_time (w_rtime[i]),
            .i_head_attr  (w_attr[0]),
            .i_head_limit (w_limit[0]),
            .i_head_time  (w_head_time),
            .o_attr       (w_attr[i]),
            .o_limit      (w_limit[i]),
            .o_time       (w_time[i])
        );
    end

    // Sequencer and entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_left  <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        if (i_req.opcode == OP_ADD) begin
                            r_state <= ST_FLUSH;
                            if (!w_full) begin
                                r_count <= r_count + 1'b1;
                            end
                        end else if (r_count == '0) begin
                            r_state <= ST_FLUSH;
                        end else begin
                            r_state <= ST_UPD;
                            r_left  <= r_count;
                        end
                    end
                end
                ST_UPD: begin
                    if (r_left == CNT_W'(1)) begin
                        r_state <= ST_EXP;
                        r_left  <= r_count;
                    end else begin
                        r_left <= r_left - 1'b1;
                    end
                end
                ST_EXP: begin
                    r_left <= r_left - 1'b1;
                    if (w_drop) begin
                        r_count <= r_count - 1'b1;
                    end
                    if (r_left == CNT_W'(1)) begin
                        r_state <= ST_FLUSH;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_delta <= i_req.delta_time;
        end
    end

    // Result holding: one result waits until the next shows whether it is last
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_vld <= 1'b0;
            r_strobe   <= 1'b0;
            r_nres     <= '0;
        end else begin
            if (w_accept) begin
                r_strobe <= 1'b0;
                r_nres   <= '0;
                if (i_req.opcode == OP_ADD) begin
                    r_pend_vld <= 1'b1;
                end
            end else if (r_state == ST_FLUSH) begin
                r_strobe   <= r_pend_vld;
                r_pend_vld <= 1'b0;
            end else if (w_new_vld && (r_nres < NRES_W'(MAX_RESULTS))) begin
                r_strobe   <= r_pend_vld;
                r_pend_vld <= 1'b1;
                r_nres     <= r_nres + 1'b1;
            end else begin
                r_strobe <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pend <= '{kind: w_full ? KIND_REJECTED : KIND_ADDED,
                        reported_tag: i_req.event_tag, elapsed: 32'd0, last: 1'b0};
        end else if (r_state == ST_FLUSH) begin
            r_out <= '{kind: r_pend.kind, reported_tag: r_pend.reported_tag,
                       elapsed: r_pend.elapsed, last: 1'b1};
        end else if (w_new_vld && (r_nres < NRES_W'(MAX_RESULTS))) begin
            r_out  <= r_pend;
            r_pend <= w_new;
        end
    end

    assign o_busy   = (r_state != ST_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_out;

    // Checks
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(EVENT_SLOTS))
        else $error("entry count above table size");

    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_pend_vld)
        else $error("result still held while idle");

    a_flush_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FLUSH) |=> (r_state == ST_IDLE))
        else $error("flush did not return to idle");

    a_last_from_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.last) |-> ($past(r_state) == ST_FLUSH))
        else $error("final result outside flush");

    a_update_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPD) |=> (r_count == $past(r_count)))
        else $error("entry count changed during update pass");

endmodule

`default_nettype wire
